// File: rtl/scatter_gather_copy_planner_core_defines.svh
// Assertion macros shared by the scatter-gather copy planner RTL.
`ifndef SCATTER_GATHER_COPY_PLANNER_CORE_DEFINES_SVH
`define SCATTER_GATHER_COPY_PLANNER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define SGCP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgcp assertion failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define SGCP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgcp assertion failed");

`endif

// File: rtl/sgcp_pkg.sv
// Shared types and constants of the scatter-gather copy planner.
`default_nettype none

package sgcp_pkg;

	localparam int LEN_W       = 13;
	localparam int REG_W       = 18;
	localparam int KIND_W      = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int MAX_RESULTS = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [KIND_W-1:0] KIND_SRC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DST   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COPY_LENGTH  = 1'b1;

	typedef struct packed {
		logic [REG_W-1:0] start_offset;
		logic [REG_W-1:0] copy_length;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/scatter_gather_copy_planner_core.sv
// A segment load is taken by the back end from idle; a start runs the single-step walk
// sequencer through the idle pop, a skip step per skipped segment, the skip exit, the walk
// steps (at most 2 * MAX_SEGMENTS) and the summary, and reads its tables through registered
// reads. A full output register stalls the walk only on a step that emits a beat.
// Reset (arst_n low, asynchronous): queue, lists and output empty; drop flag and config zero.
`default_nettype none

module scatter_gather_copy_planner_core #(
	parameter int MAX_SEGMENTS = 32,
	parameter int PAGE_BYTES = 4096,
	parameter int ADDR_BITS = 48,
	localparam int IN_W = ((ADDR_BITS + sgcp_pkg::LEN_W + 7) / 8) * 8,
	localparam int OUT_W = ((2 * ADDR_BITS + sgcp_pkg::LEN_W + sgcp_pkg::REG_W + 1 + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input beats.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// tdata from bit 0: seg_addr, seg_length, zero fill.
	input  wire logic [IN_W-1:0]                s_tdata,
	// tuser: kind.
	input  wire logic [sgcp_pkg::KIND_W-1:0]    s_tuser,
	// Result beats.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// tdata from bit 0: src_addr, dst_addr, byte_count, copied_bytes, overflow, zero fill.
	output logic      [OUT_W-1:0]               m_tdata,
	// tuser: is_summary.
	output logic                                m_tuser,
	output logic                                m_tlast,
	// Configuration writes.
	input  wire logic                           cfg_we,
	input  wire logic [sgcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sgcp_pkg::REG_W-1:0]     cfg_wdata
);

	localparam int QW = sgcp_pkg::KIND_W + ADDR_BITS + sgcp_pkg::LEN_W;

	sgcp_pkg::cfg_t cfg_q;

	logic          q_push, q_full, q_pop, q_valid;
	logic [QW-1:0] q_in, q_out;

	logic                           o_summary, o_ovf;
	logic [ADDR_BITS-1:0]           o_src, o_dst;
	logic [sgcp_pkg::LEN_W-1:0]     o_count;
	logic [sgcp_pkg::REG_W-1:0]     o_total;

	// Configuration registers; the user must write them only while the planner is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sgcp_pkg::CFG_START_OFFSET: cfg_q.start_offset <= cfg_wdata;
				sgcp_pkg::CFG_COPY_LENGTH:  cfg_q.copy_length  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Front: take beats, drop unknown kinds, clamp lengths, push to the queue.
	sgcp_front #(.ADDR_BITS(ADDR_BITS), .PAGE_BYTES(PAGE_BYTES)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	// Queue: loads keep their order against starts, so a start sees exactly
	// the descriptors that came before it.
	sgcp_fifo #(.W(QW), .DEPTH(sgcp_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	// Back: table writes, offset skip, paired walk, summary, output register.
	sgcp_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.o_summary (o_summary),
		.o_src     (o_src),
		.o_dst     (o_dst),
		.o_count   (o_count),
		.o_total   (o_total),
		.o_ovf     (o_ovf)
	);

	// Pack the result beat; the summary is always the last beat of a start run.
	assign m_tdata = OUT_W'({o_ovf, o_total, o_count, o_dst, o_src});
	assign m_tuser = o_summary;
	assign m_tlast = o_summary;

endmodule

`default_nettype wire

// File: rtl/sgcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sgcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/sgcp_fifo.sv
// Short item queue between the front and the back of the planner.
`default_nettype none

module sgcp_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              valid,
	output logic      [W-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign valid    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/sgcp_front.sv
// Input side: accept beats, drop unknown kinds, clamp segment lengths to a page.
`default_nettype none

module sgcp_front #(
	parameter int ADDR_BITS = 48,
	parameter int PAGE_BYTES = 4096,
	localparam int IN_W = ((ADDR_BITS + sgcp_pkg::LEN_W + 7) / 8) * 8,
	localparam int QW = sgcp_pkg::KIND_W + ADDR_BITS + sgcp_pkg::LEN_W
) (
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [IN_W-1:0]             s_tdata,
	input  wire logic [sgcp_pkg::KIND_W-1:0] s_tuser,
	input  wire logic                        q_full,
	output logic                             q_push,
	output logic      [QW-1:0]               q_data
);

	logic [sgcp_pkg::LEN_W-1:0] raw_len;
	logic [sgcp_pkg::LEN_W-1:0] len;
	logic [ADDR_BITS-1:0]       addr;
	logic                       known;

	assign addr    = s_tdata[ADDR_BITS-1:0];
	assign raw_len = s_tdata[ADDR_BITS +: sgcp_pkg::LEN_W];
	assign len     = (32'(raw_len) > 32'(PAGE_BYTES)) ? sgcp_pkg::LEN_W'(PAGE_BYTES) : raw_len;
	assign known   = s_tuser inside {sgcp_pkg::KIND_SRC, sgcp_pkg::KIND_DST,
		sgcp_pkg::KIND_START};

	// Unknown kinds are taken and dropped without reaching the queue.
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && known;
	assign q_data   = {s_tuser, addr, len};

endmodule

`default_nettype wire

// File: rtl/sgcp_back.sv
// Execution side: segment tables, offset skip, list walk and result register.
`default_nettype none

`include "scatter_gather_copy_planner_core_defines.svh"

module sgcp_back #(
	parameter int MAX_SEGMENTS = 32,
	parameter int ADDR_BITS = 48,
	localparam int QW = sgcp_pkg::KIND_W + ADDR_BITS + sgcp_pkg::LEN_W
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sgcp_pkg::cfg_t        cfg,
	input  wire logic                  q_valid,
	input  wire logic [QW-1:0]         q_data,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic                       o_summary,
	output logic [ADDR_BITS-1:0]       o_src,
	output logic [ADDR_BITS-1:0]       o_dst,
	output logic [sgcp_pkg::LEN_W-1:0] o_count,
	output logic [sgcp_pkg::REG_W-1:0] o_total,
	output logic                       o_ovf
);

	localparam int LW = sgcp_pkg::LEN_W;
	localparam int RW = sgcp_pkg::REG_W;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int EW = ADDR_BITS + LW;
	localparam int NW = $clog2(sgcp_pkg::MAX_RESULTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [1:0]    state_q, state_n;
	logic [CW-1:0] src_cnt_q, src_cnt_n;
	logic [CW-1:0] dst_cnt_q, dst_cnt_n;
	logic          drop_q, drop_n;
	logic [CW-1:0] s_q, s_n;
	logic [CW-1:0] d_q, d_n;
	logic [RW-1:0] soff_q, soff_n;
	logic [LW-1:0] doff_q, doff_n;
	logic [RW-1:0] left_q, left_n;
	logic [NW-1:0] n_q, n_n;

	logic                 ov_q;
	logic                 out_sum_q, out_sum_n;
	logic [ADDR_BITS-1:0] out_src_q, out_src_n;
	logic [ADDR_BITS-1:0] out_dst_q, out_dst_n;
	logic [LW-1:0]        out_cnt_q, out_cnt_n;
	logic [RW-1:0]        out_tot_q, out_tot_n;
	logic                 out_ovf_q, out_ovf_n;
	logic                 load_out;

	logic [sgcp_pkg::KIND_W-1:0] q_kind;
	logic [ADDR_BITS-1:0]        q_addr;
	logic [LW-1:0]               q_len;

	logic          src_we, dst_we;
	logic [EW-1:0] src_rdata, dst_rdata;

	logic [LW-1:0]        slen, dlen;
	logic [ADDR_BITS-1:0] saddr, daddr;
	logic                 s_live, d_live;
	logic [LW-1:0]        srem, drem, nbytes, copied, doff_sum;
	logic [RW-1:0]        soff_sum;
	logic                 want_cmd;
	logic                 out_free;

	assign {q_kind, q_addr, q_len} = q_data;

	// Read address follows the next index, so read data always matches s_q / d_q.
	sgcp_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (src_cnt_q[IW-1:0]),
		.wdata ({q_addr, q_len}),
		.raddr (s_n[IW-1:0]),
		.rdata (src_rdata)
	);

	sgcp_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_dst_ram (
		.clk   (clk),
		.we    (dst_we),
		.waddr (dst_cnt_q[IW-1:0]),
		.wdata ({q_addr, q_len}),
		.raddr (d_n[IW-1:0]),
		.rdata (dst_rdata)
	);

	assign slen  = src_rdata[LW-1:0];
	assign saddr = src_rdata[LW +: ADDR_BITS];
	assign dlen  = dst_rdata[LW-1:0];
	assign daddr = dst_rdata[LW +: ADDR_BITS];

	assign s_live   = (s_q < src_cnt_q);
	assign d_live   = (d_q < dst_cnt_q);
	assign srem     = slen - soff_q[LW-1:0];
	assign nbytes   = (RW'(srem) < left_q) ? srem : left_q[LW-1:0];
	assign drem     = dlen - doff_q;
	assign copied   = (nbytes < drem) ? nbytes : drem;
	assign doff_sum = doff_q + copied;
	assign soff_sum = soff_q + RW'(copied);
	assign want_cmd = (copied != '0) && (n_q < NW'(sgcp_pkg::MAX_RESULTS - 1));
	assign out_free = !ov_q || m_tready;

	always_comb begin
		state_n   = state_q;
		src_cnt_n = src_cnt_q;
		dst_cnt_n = dst_cnt_q;
		drop_n    = drop_q;
		s_n       = s_q;
		d_n       = d_q;
		soff_n    = soff_q;
		doff_n    = doff_q;
		left_n    = left_q;
		n_n       = n_q;
		q_pop     = 1'b0;
		src_we    = 1'b0;
		dst_we    = 1'b0;
		load_out  = 1'b0;
		out_sum_n = out_sum_q;
		out_src_n = out_src_q;
		out_dst_n = out_dst_q;
		out_cnt_n = out_cnt_q;
		out_tot_n = out_tot_q;
		out_ovf_n = out_ovf_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_kind)
						sgcp_pkg::KIND_SRC: begin
							if (src_cnt_q < CW'(MAX_SEGMENTS)) begin
								src_we    = 1'b1;
								src_cnt_n = src_cnt_q + 1'b1;
							end else begin
								drop_n = 1'b1;
							end
						end
						sgcp_pkg::KIND_DST: begin
							if (dst_cnt_q < CW'(MAX_SEGMENTS)) begin
								dst_we    = 1'b1;
								dst_cnt_n = dst_cnt_q + 1'b1;
							end else begin
								drop_n = 1'b1;
							end
						end
						sgcp_pkg::KIND_START: begin
							s_n     = '0;
							d_n     = '0;
							soff_n  = cfg.start_offset;
							doff_n  = '0;
							left_n  = cfg.copy_length;
							n_n     = '0;
							state_n = ST_SKIP;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SKIP: begin
				if (s_live && (soff_q > RW'(slen))) begin
					soff_n = soff_q - RW'(slen);
					s_n    = s_q + 1'b1;
				end else begin
					state_n = ST_WALK;
				end
			end
			ST_WALK: begin
				if (s_live && d_live && (left_q != '0)) begin
					// Hold the step while a command cannot enter the output register.
					if (!want_cmd || out_free) begin
						if (want_cmd) begin
							load_out  = 1'b1;
							out_sum_n = 1'b0;
							out_src_n = saddr + ADDR_BITS'(soff_q);
							out_dst_n = daddr + ADDR_BITS'(doff_q);
							out_cnt_n = copied;
							out_tot_n = '0;
							out_ovf_n = 1'b0;
							n_n       = n_q + 1'b1;
						end
						left_n = left_q - RW'(copied);
						if (doff_sum == dlen) begin
							doff_n = '0;
							d_n    = d_q + 1'b1;
						end else begin
							doff_n = doff_sum;
						end
						if (soff_sum == RW'(slen)) begin
							soff_n = '0;
							s_n    = s_q + 1'b1;
						end else begin
							soff_n = soff_sum;
						end
					end
				end else if (out_free) begin
					load_out  = 1'b1;
					out_sum_n = 1'b1;
					out_src_n = '0;
					out_dst_n = '0;
					out_cnt_n = '0;
					out_tot_n = cfg.copy_length - left_q;
					out_ovf_n = drop_q;
					src_cnt_n = '0;
					dst_cnt_n = '0;
					drop_n    = 1'b0;
					state_n   = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			src_cnt_q <= '0;
			dst_cnt_q <= '0;
			drop_q    <= 1'b0;
			s_q       <= '0;
			d_q       <= '0;
			n_q       <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_n;
			src_cnt_q <= src_cnt_n;
			dst_cnt_q <= dst_cnt_n;
			drop_q    <= drop_n;
			s_q       <= s_n;
			d_q       <= d_n;
			n_q       <= n_n;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		soff_q    <= soff_n;
		doff_q    <= doff_n;
		left_q    <= left_n;
		out_sum_q <= out_sum_n;
		out_src_q <= out_src_n;
		out_dst_q <= out_dst_n;
		out_cnt_q <= out_cnt_n;
		out_tot_q <= out_tot_n;
		out_ovf_q <= out_ovf_n;
	end

	assign m_tvalid  = ov_q;
	assign o_summary = out_sum_q;
	assign o_src     = out_src_q;
	assign o_dst     = out_dst_q;
	assign o_count   = out_cnt_q;
	assign o_total   = out_tot_q;
	assign o_ovf     = out_ovf_q;

	`SGCP_ASSERT_IMP(a_cnt_bound, 1'b1,
		(src_cnt_q <= CW'(MAX_SEGMENTS)) && (dst_cnt_q <= CW'(MAX_SEGMENTS)))
	`SGCP_ASSERT_IMP(a_soff_in_seg, (state_q == ST_WALK) && s_live, soff_q <= RW'(slen))
	`SGCP_ASSERT_IMP(a_doff_in_seg, (state_q == ST_WALK) && d_live, doff_q <= dlen)
	`SGCP_ASSERT_NXT(a_summary_clears, load_out && out_sum_n,
		(src_cnt_q == '0) && (dst_cnt_q == '0) && !drop_q && (state_q == ST_IDLE))

endmodule

`default_nettype wire

// File: tb/scatter_gather_copy_planner_core_tb.sv
// Self-checking stream testbench for the scatter-gather copy planner core.
module scatter_gather_copy_planner_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W          = 48;
	localparam int MAX_SEGS        = 32;
	localparam int PAGE_LIMIT      = 4096;
	localparam int IN_W            = 64;
	localparam int OUT_W           = 128;
	localparam int KIND_W          = sgcp_pkg::KIND_W;
	localparam int LEN_W           = sgcp_pkg::LEN_W;
	localparam int REG_W           = sgcp_pkg::REG_W;
	localparam int CFG_IDX_W       = sgcp_pkg::CFG_IDX_W;
	// Loads may still sit in the input queue; allow a full walk on top.
	localparam int DRAIN_CYCLES    = 2 * MAX_SEGS + 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_ITEMS    = 130;
	localparam int REPORT_LIMIT    = 10;

	// The fourth kind code has no meaning; the block swallows it without a result.
	localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
	localparam logic [REG_W-1:0]  REG_MAX      = 18'd131072;

	// One copy command or run summary, in the order of the result fields.
	typedef struct packed {
		logic              summary;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [LEN_W-1:0]  count;
		logic [REG_W-1:0]  total;
		logic              ovf;
		logic              closes_run;
	} copy_beat_t;

	typedef enum logic [1:0] {ROW_CONFIG, ROW_BEAT, ROW_BEAT_TYPED} row_op_t;

	// ROW_CONFIG: val_a = start offset, val_b = copy length.
	// ROW_BEAT_TYPED: a start whose lone summary is typed in; val_a = total, val_b[0] = overflow.
	typedef struct packed {
		row_op_t           op;
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  seg_len;
		logic [REG_W-1:0]  val_a;
		logic [REG_W-1:0]  val_b;
	} stim_row_t;

	localparam int DIRECTED_COUNT = 24;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// empty lists right after reset: summary only, zero bytes
		'{ROW_BEAT_TYPED, sgcp_pkg::KIND_START, 48'h0, 13'd0, 18'd0, 18'd0},
		// full request; page-sized, zero-length and oversized segments, wrap past the top
		'{ROW_CONFIG, sgcp_pkg::KIND_SRC, 48'h0, 13'd0, 18'd0, REG_MAX},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'hFFFF_FFFF_FF00, 13'd4096, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'h0000_0000_0000, 13'd0, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'h1234_5678_9ABC, 13'd300, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'h8000_0000_1000, 13'd8191, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'h0000_0000_0000, 13'd0, 18'd0, 18'd0},
		'{ROW_BEAT, KIND_IGNORED, 48'hFFFF_FFFF_FFFF, 13'd8191, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'hFFFF_FFFF_FFF0, 13'd5000, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_START, 48'h0, 13'd0, 18'd0, 18'd0},
		// offset lands exactly on the end of the first source segment
		'{ROW_CONFIG, sgcp_pkg::KIND_SRC, 48'h0, 13'd0, 18'd4096, 18'd5000},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'h0000_0000_1000, 13'd4096, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'h0000_0000_9000, 13'd2048, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'h0000_000A_0000, 13'd4096, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'h7FFF_FFFF_F000, 13'd4096, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_START, 48'h0, 13'd0, 18'd0, 18'd0},
		// offset beyond the whole source list
		'{ROW_CONFIG, sgcp_pkg::KIND_SRC, 48'h0, 13'd0, REG_MAX, 18'd1000},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'h5555_5555_5555, 13'd100, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'hAAAA_AAAA_AAAA, 13'd100, 18'd0, 18'd0},
		'{ROW_BEAT_TYPED, sgcp_pkg::KIND_START, 48'h0, 13'd0, 18'd0, 18'd0},
		// nothing requested
		'{ROW_CONFIG, sgcp_pkg::KIND_SRC, 48'h0, 13'd0, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_SRC, 48'h0000_0000_2000, 13'd512, 18'd0, 18'd0},
		'{ROW_BEAT, sgcp_pkg::KIND_DST, 48'h0000_0000_3000, 13'd512, 18'd0, 18'd0},
		'{ROW_BEAT_TYPED, sgcp_pkg::KIND_START, 48'h0, 13'd0, 18'd0, 18'd0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;
	logic [KIND_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;

	scatter_gather_copy_planner_core #(
		.MAX_SEGMENTS(MAX_SEGS),
		.PAGE_BYTES(PAGE_LIMIT),
		.ADDR_BITS(ADDR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow of the planner: segment lists, fill counts, drop flag and registers.
	logic [ADDR_W-1:0] src_seg_addr [MAX_SEGS];
	int unsigned       src_seg_len  [MAX_SEGS];
	logic [ADDR_W-1:0] dst_seg_addr [MAX_SEGS];
	int unsigned       dst_seg_len  [MAX_SEGS];
	int unsigned       src_loaded = 0;
	int unsigned       dst_loaded = 0;
	bit                drop_seen = 1'b0;
	int unsigned       plan_offset = 0;
	int unsigned       plan_length = 0;

	// Commands and summaries still owed by the block, oldest first.
	copy_beat_t pending_beats[$];

	int         error_count = 0;
	int         beats_seen = 0;
	int         items_sent = 0;
	int         cycle_count = 0;
	bit         tight_phase = 1'b0;
	bit         hold_off_armed = 1'b0;
	copy_beat_t seen_beat;
	copy_beat_t want_beat;

	// Apply one input beat to the shadow and return the beats it must produce.
	function automatic void plan_copy(input logic [KIND_W-1:0] kind,
			input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] raw_len,
			ref copy_beat_t beats[$]);
		int unsigned seg_len, s, d, soff, doff, left, chunk, room;
		copy_beat_t cmd;
		beats.delete();
		// saturate anything longer than a page
		seg_len = (32'(raw_len) > PAGE_LIMIT) ? PAGE_LIMIT : 32'(raw_len);
		if (kind == sgcp_pkg::KIND_SRC) begin
			if (src_loaded < MAX_SEGS) begin
				src_seg_addr[src_loaded] = addr;
				src_seg_len[src_loaded] = seg_len;
				src_loaded++;
			end else begin
				drop_seen = 1'b1;
			end
		end else if (kind == sgcp_pkg::KIND_DST) begin
			if (dst_loaded < MAX_SEGS) begin
				dst_seg_addr[dst_loaded] = addr;
				dst_seg_len[dst_loaded] = seg_len;
				dst_loaded++;
			end else begin
				drop_seen = 1'b1;
			end
		end else if (kind == sgcp_pkg::KIND_START) begin
			s = 0;
			d = 0;
			doff = 0;
			soff = plan_offset;
			left = plan_length;
			// skip whole source segments; an offset equal to a segment's length stays put
			while (s < src_loaded && soff > src_seg_len[s]) begin
				soff -= src_seg_len[s];
				s++;
			end
			while (s < src_loaded && d < dst_loaded && left != 0) begin
				chunk = src_seg_len[s] - soff;
				if (left < chunk)
					chunk = left;
				room = dst_seg_len[d] - doff;
				if (room < chunk)
					chunk = room;
				// zero-byte steps only advance the walk
				if (chunk != 0 && beats.size() < sgcp_pkg::MAX_RESULTS - 1) begin
					cmd = '0;
					cmd.src = src_seg_addr[s] + ADDR_W'(soff);
					cmd.dst = dst_seg_addr[d] + ADDR_W'(doff);
					cmd.count = LEN_W'(chunk);
					beats.push_back(cmd);
				end
				left -= chunk;
				doff += chunk;
				if (doff == dst_seg_len[d]) begin
					doff = 0;
					d++;
				end
				soff += chunk;
				if (soff == src_seg_len[s]) begin
					soff = 0;
					s++;
				end
			end
			cmd = '0;
			cmd.summary = 1'b1;
			cmd.total = REG_W'(plan_length - left);
			cmd.ovf = drop_seen;
			cmd.closes_run = 1'b1;
			beats.push_back(cmd);
			// a start always empties both lists and clears the drop flag
			src_loaded = 0;
			dst_loaded = 0;
			drop_seen = 1'b0;
		end
	endfunction

	function automatic logic [LEN_W-1:0] random_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LEN_W'(PAGE_LIMIT);
			2: return LEN_W'($urandom_range(PAGE_LIMIT + 1, 8191));
			3, 4: return LEN_W'($urandom_range(1, 64));
			default: return LEN_W'($urandom_range(1, PAGE_LIMIT - 1));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] random_addr();
		logic [ADDR_W-1:0] a;
		a = ADDR_W'({$urandom, $urandom});
		// park some segments just under the top so that offsets wrap
		if ($urandom_range(0, 7) == 0)
			a[ADDR_W-1:12] = '1;
		return a;
	endfunction

	// Offer one beat after a random gap, hold it until taken, then predict.
	// Returns at a falling edge with tvalid still high, so that the next
	// call can either lower it or replace the beat without a second update.
	task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] seg_len, input bit typed,
			input logic [REG_W-1:0] typed_total, input logic typed_ovf);
		int gap, r;
		copy_beat_t beats[$];
		copy_beat_t closing;
		r = $urandom_range(0, 99);
		if (tight_phase || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= kind;
		s_tdata <= {3'b000, seg_len, addr};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		plan_copy(kind, addr, seg_len, beats);
		if (typed) begin
			// the summary is known up front; still run the shadow to keep its state
			closing = '0;
			closing.summary = 1'b1;
			closing.total = typed_total;
			closing.ovf = typed_ovf;
			closing.closes_run = 1'b1;
			beats.delete();
			beats.push_back(closing);
		end
		foreach (beats[i])
			pending_beats.push_back(beats[i]);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop tvalid, wait for every owed beat, then let queued loads drain.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_config(input logic [REG_W-1:0] offset, input logic [REG_W-1:0] length);
		cfg_we <= 1'b1;
		cfg_index <= sgcp_pkg::CFG_START_OFFSET;
		cfg_wdata <= offset;
		@(negedge clk);
		cfg_index <= sgcp_pkg::CFG_COPY_LENGTH;
		cfg_wdata <= length;
		@(negedge clk);
		cfg_we <= 1'b0;
		plan_offset = 32'(offset);
		plan_length = 32'(length);
	endtask

	// Load the two lists in random interleaving, with stray ignored beats, then start.
	task automatic load_and_start(input int n_src, input int n_dst, input bit short_segs);
		int src_left, dst_left;
		logic [LEN_W-1:0] seg_len;
		src_left = n_src;
		dst_left = n_dst;
		while (src_left + dst_left > 0) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(KIND_IGNORED, random_addr(), LEN_W'($urandom), 1'b0, '0, 1'b0);
			seg_len = short_segs ? LEN_W'($urandom_range(0, 200)) : random_len();
			if (dst_left == 0 || (src_left > 0 && $urandom_range(0, 1) == 0)) begin
				send_beat(sgcp_pkg::KIND_SRC, random_addr(), seg_len, 1'b0, '0, 1'b0);
				src_left--;
			end else begin
				send_beat(sgcp_pkg::KIND_DST, random_addr(), seg_len, 1'b0, '0, 1'b0);
				dst_left--;
			end
		end
		// a start ignores its data fields; fill them with noise
		send_beat(sgcp_pkg::KIND_START, random_addr(), random_len(), 1'b0, '0, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** scatter_gather_copy_planner_core: FAILED **");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off when armed, ready streaks.
	initial begin : result_sink
		int stall_left, streak_left, r;
		stall_left = 0;
		streak_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_armed && m_tvalid) begin
				hold_off_armed = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (streak_left > 0) begin
				streak_left--;
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					m_tready <= 1'b1;
				end else if (r < 85) begin
					stall_left = $urandom_range(0, 2);
					m_tready <= 1'b0;
				end else if (r < 95) begin
					streak_left = $urandom_range(20, 80);
					m_tready <= 1'b1;
				end else begin
					stall_left = $urandom_range(10, 60);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Compare each accepted result beat against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_beat.summary = m_tuser;
			seen_beat.src = m_tdata[47:0];
			seen_beat.dst = m_tdata[95:48];
			seen_beat.count = m_tdata[108:96];
			seen_beat.total = m_tdata[126:109];
			seen_beat.ovf = m_tdata[127];
			seen_beat.closes_run = m_tlast;
			if (pending_beats.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("result beat %0d not owed: summary=%0b src=%h dst=%h count=%0d",
						beats_seen, seen_beat.summary, seen_beat.src, seen_beat.dst,
						seen_beat.count);
			end else begin
				want_beat = pending_beats.pop_front();
				if (seen_beat !== want_beat) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("result beat %0d: expected summary=%0b src=%h dst=%h count=%0d",
							beats_seen, want_beat.summary, want_beat.src, want_beat.dst,
							want_beat.count);
						$display("    total=%0d ovf=%0b last=%0b; got summary=%0b src=%h dst=%h",
							want_beat.total, want_beat.ovf, want_beat.closes_run,
							seen_beat.summary, seen_beat.src, seen_beat.dst);
						$display("    count=%0d total=%0d ovf=%0b last=%0b",
							seen_beat.count, seen_beat.total, seen_beat.ovf,
							seen_beat.closes_run);
					end
				end
			end
			beats_seen++;
		end
	end

	initial begin : stimulus
		int phase, runs, n_src, n_dst;
		logic [REG_W-1:0] offset, length;
		stim_row_t row;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table; the first start runs on the reset registers.
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			row = DIRECTED_ROWS[i];
			case (row.op)
				ROW_CONFIG: begin
					wait_idle();
					write_config(row.val_a, row.val_b);
				end
				ROW_BEAT: begin
					send_beat(row.kind, row.addr, row.seg_len, 1'b0, '0, 1'b0);
				end
				default: begin
					send_beat(row.kind, row.addr, row.seg_len, 1'b1, row.val_a, row.val_b[0]);
				end
			endcase
		end

		// Random phases: fresh registers while idle, then one to three load-and-start runs.
		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 7))
				0: offset = '0;
				1: offset = REG_MAX;
				default: offset = REG_W'($urandom_range(0, 6000));
			endcase
			case ($urandom_range(0, 7))
				0: length = '0;
				1: length = REG_MAX;
				default: length = REG_W'($urandom_range(1, 12000));
			endcase
			if (phase == 0) begin
				offset = '0;
				length = REG_MAX;
			end
			write_config(offset, length);
			tight_phase = (phase == 1) || ($urandom_range(0, 4) == 0);
			if (phase == 0) begin
				// overfill both lists with short segments: the extra loads are dropped
				// and flagged, and the walk runs its longest train of commands
				load_and_start(MAX_SEGS + 2, MAX_SEGS + 1, 1'b1);
			end else if (phase == 1) begin
				// hold the result side off at the first result and keep offering
				// beats, so the input queue fills and the block stalls its input
				hold_off_armed = 1'b1;
				repeat (3) load_and_start(6, 6, 1'b0);
			end else begin
				runs = $urandom_range(1, 3);
				repeat (runs) begin
					n_src = $urandom_range(0, 8);
					n_dst = $urandom_range(0, 8);
					// now and then start on an empty list
					if ($urandom_range(0, 9) == 0)
						n_src = 0;
					load_and_start(n_src, n_dst, 1'b0);
				end
			end
			phase++;
		end

		wait_idle();
		if (error_count == 0 && pending_beats.size() == 0)
			$display("** scatter_gather_copy_planner_core: PASSED **");
		else
			$display("** scatter_gather_copy_planner_core: FAILED **");
		$finish;
	end

endmodule
